// ===== hw/rtl/edge_block_scatter_top_assert.svh =====
// Assertion macros for the edge block scatter engine.
`ifndef EDGE_BLOCK_SCATTER_TOP_ASSERT_SVH
`define EDGE_BLOCK_SCATTER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define EBS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset.
`define EBS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/ebs_pkg.sv =====
// Types and codes shared by the edge block scatter engine.
`default_nettype none
package ebs_pkg;

    typedef enum logic [2:0] {
        KIND_STORED = 3'd0,
        KIND_FULL   = 3'd1,
        KIND_SELF   = 3'd2,
        KIND_RANGE  = 3'd3,
        KIND_FLUSH  = 3'd4,
        KIND_NONE   = 3'd5
    } t_kind;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_LOOK,
        S_UPD,
        S_OUT,
        S_SCAN,
        S_SDAT,
        S_SOUT,
        S_SEND
    } t_state;

    localparam logic [1:0] CFG_PARTITIONS = 2'd0;
    localparam logic [1:0] CFG_INTERVAL   = 2'd1;
    localparam logic [1:0] CFG_CAPACITY   = 2'd2;

    localparam logic [3:0]  RST_PARTITIONS = 4'd8;
    localparam logic [31:0] RST_INTERVAL   = 32'd536870912;
    localparam logic [15:0] RST_CAPACITY   = 16'd4096;

endpackage
`default_nettype wire

// ===== hw/rtl/edge_block_scatter_top.sv =====
// Edge block scatter engine: bins graph edges into grid blocks and tracks block fill.
`default_nettype none
// Each edge request is accepted, then runs the interval search (a shared
// one-bit-per-cycle quotient step for source and destination), reads the block's
// fill counter from the fill memory in S_LOOK, and updates it and loads the result
// in S_UPD; an edge outside the configured partitions skips the read and update and
// answers with a range result. The next request is taken once that result has been
// delivered. Self-loops answer in the cycle after acceptance. An end-of-stream
// request walks all MAX_PARTITIONS^2 fill counters in block order and delivers a
// flush result for each filled block; the final result is marked last. Fill
// counters reset to zero through per-block valid bits, so no clearing pass is needed
// after reset. The configuration port is always ready; write it only while the engine is idle.
module edge_block_scatter_top
    import ebs_pkg::*;
#(
    parameter int MAX_PARTITIONS = 8,
    parameter int COUNTER_BITS   = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_mode,
    input  wire logic [31:0] i_src_vertex,
    input  wire logic [31:0] i_dst_vertex,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [2:0]       o_kind,
    output logic [5:0]       o_block_id,
    output logic [15:0]      o_slot,
    output logic [21:0]      o_buffer_address,
    output logic [15:0]      o_flush_count,
    output logic [39:0]      o_edges_written,
    output logic [39:0]      o_self_loops_dropped,
    output logic             o_last
);

    localparam int NB   = MAX_PARTITIONS * MAX_PARTITIONS;
    localparam int BW   = (NB > 1) ? $clog2(NB) : 1;
    localparam int CB   = COUNTER_BITS;
    localparam logic [BW-1:0] LAST_BLK = BW'(NB - 1);
    localparam logic [32:0] CNT_MAX = 33'((64'd1 << CB) - 64'd1);
    localparam logic [3:0]  MAXP    = 4'(MAX_PARTITIONS);
    localparam logic [39:0] TOT_MAX = {40{1'b1}};

    // configuration
    logic [3:0]  r_cfg_parts;
    logic [31:0] r_cfg_isz;
    logic [15:0] r_cfg_cap;

    logic [3:0]  parts_eff;
    logic [31:0] isz_eff;
    logic [15:0] cap_eff;
    logic [32:0] cap_wide;

    t_state r_state, n_state;

    logic [1:0]  r_step;
    logic [31:0] r_src_rem, r_dst_rem;
    logic [3:0]  r_src_q, r_dst_q;
    logic [5:0]  r_blk;
    logic [BW-1:0] r_idx;
    logic        r_scan_end;

    logic        r_pend_vld;
    logic [5:0]  r_pend_blk;
    logic [15:0] r_pend_fill;
    logic [21:0] r_pend_addr;

    t_kind       r_o_kind;
    logic [5:0]  r_o_blk;
    logic [15:0] r_o_slot;
    logic [21:0] r_o_addr;
    logic [15:0] r_o_flush;
    logic        r_o_last;

    logic [39:0] r_stored_total, r_loop_total;

    // fill memory and per-block valid bits
    logic [CB-1:0] mem [NB];
    logic [NB-1:0] r_vld;
    logic [CB-1:0] r_rdata;
    logic          r_rd_vld;
    logic          rd_en;
    logic [BW-1:0] rd_addr;

    logic        in_acc, out_acc;
    logic [35:0] src_div, dst_div;
    logic        src_ge, dst_ge;
    logic        out_range;
    logic [5:0]  blk_calc;
    logic [CB-1:0] fill_now;
    logic [32:0] fill_next;
    logic        blk_full;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_parts <= RST_PARTITIONS;
            r_cfg_isz   <= RST_INTERVAL;
            r_cfg_cap   <= RST_CAPACITY;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PARTITIONS: r_cfg_parts <= i_cfg_data[3:0];
                CFG_INTERVAL:   r_cfg_isz   <= i_cfg_data;
                CFG_CAPACITY:   r_cfg_cap   <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_cfg_parts == 4'd0) begin
            parts_eff = 4'd1;
        end else if (r_cfg_parts > MAXP) begin
            parts_eff = MAXP;
        end else begin
            parts_eff = r_cfg_parts;
        end
        isz_eff = (r_cfg_isz == 32'd0) ? 32'd1 : r_cfg_isz;
        cap_wide = (r_cfg_cap == 16'd0) ? 33'd1 : 33'(r_cfg_cap);
        if (cap_wide > CNT_MAX) begin
            cap_wide = CNT_MAX;
        end
        cap_eff = cap_wide[15:0];
    end

    assign in_acc  = i_in_valid && !o_in_stall;
    assign out_acc = o_out_valid && !i_out_stall;

    // one quotient bit per cycle, saturating at 15
    assign src_div = {4'd0, isz_eff} << r_step;
    assign dst_div = {4'd0, isz_eff} << r_step;
    assign src_ge  = {4'd0, r_src_rem} >= src_div;
    assign dst_ge  = {4'd0, r_dst_rem} >= dst_div;

    assign out_range = (r_src_q >= parts_eff) || (r_dst_q >= parts_eff);
    assign blk_calc  = 6'(r_src_q[2:0] * parts_eff) + 6'(r_dst_q[2:0]);

    assign fill_now  = r_rd_vld ? r_rdata : '0;
    assign fill_next = 33'(fill_now) + 33'd1;
    assign blk_full  = fill_next >= cap_wide;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_mode) begin
                        n_state = S_SCAN;
                    end else if (i_src_vertex == i_dst_vertex) begin
                        n_state = S_OUT;
                    end else begin
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV:  n_state = (r_step == 2'd0) ? S_LOOK : S_DIV;
            S_LOOK: n_state = out_range ? S_OUT : S_UPD;
            S_UPD:  n_state = S_OUT;
            S_OUT:  n_state = out_acc ? S_IDLE : S_OUT;
            S_SCAN: begin
                if (r_vld[r_idx]) begin
                    n_state = S_SDAT;
                end else if (r_idx == LAST_BLK) begin
                    n_state = S_SEND;
                end
            end
            S_SDAT: begin
                if (r_pend_vld) begin
                    n_state = S_SOUT;
                end else begin
                    n_state = (r_idx == LAST_BLK) ? S_SEND : S_SCAN;
                end
            end
            S_SOUT: begin
                if (out_acc) begin
                    n_state = r_scan_end ? S_SEND : S_SCAN;
                end
            end
            S_SEND: n_state = S_OUT;
            default: n_state = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = r_idx;
        unique case (r_state)
            S_IDLE: o_in_stall = 1'b0;
            S_LOOK: begin
                rd_en   = !out_range;
                rd_addr = blk_calc[BW-1:0];
            end
            S_SCAN: begin
                rd_en   = r_vld[r_idx];
                rd_addr = r_idx;
            end
            S_OUT, S_SOUT: o_out_valid = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // fill memory: reads and writes never target the same cycle here
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata  <= mem[rd_addr];
            r_rd_vld <= r_vld[rd_addr];
        end
        if (r_state == S_UPD) begin
            mem[r_blk[BW-1:0]] <= blk_full ? '0 : fill_next[CB-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld          <= '0;
            r_stored_total <= '0;
            r_loop_total   <= '0;
            r_pend_vld     <= 1'b0;
            r_idx          <= '0;
            r_scan_end     <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_idx      <= '0;
                        r_pend_vld <= 1'b0;
                        if (!i_mode && i_src_vertex == i_dst_vertex &&
                            r_loop_total != TOT_MAX) begin
                            r_loop_total <= r_loop_total + 40'd1;
                        end
                    end
                end
                S_UPD: begin
                    r_vld[r_blk[BW-1:0]] <= !blk_full;
                    if (r_stored_total != TOT_MAX) begin
                        r_stored_total <= r_stored_total + 40'd1;
                    end
                end
                S_SCAN: begin
                    if (!r_vld[r_idx] && r_idx != LAST_BLK) begin
                        r_idx <= r_idx + BW'(1);
                    end
                end
                S_SDAT: begin
                    r_vld[r_idx] <= 1'b0;
                    r_pend_vld   <= 1'b1;
                    r_scan_end   <= (r_idx == LAST_BLK);
                    if (r_idx != LAST_BLK) begin
                        r_idx <= r_idx + BW'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath payload
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_src_rem <= i_src_vertex;
                r_dst_rem <= i_dst_vertex;
                r_src_q   <= '0;
                r_dst_q   <= '0;
                r_step    <= 2'd3;
                r_o_kind  <= KIND_SELF;
                r_o_blk   <= '0;
                r_o_slot  <= '0;
                r_o_addr  <= '0;
                r_o_flush <= '0;
                r_o_last  <= 1'b1;
            end
            S_DIV: begin
                if (src_ge) begin
                    r_src_rem        <= 32'({4'd0, r_src_rem} - src_div);
                    r_src_q[r_step]  <= 1'b1;
                end
                if (dst_ge) begin
                    r_dst_rem        <= 32'({4'd0, r_dst_rem} - dst_div);
                    r_dst_q[r_step]  <= 1'b1;
                end
                r_step <= r_step - 2'd1;
            end
            S_LOOK: begin
                r_blk     <= blk_calc;
                r_o_kind  <= KIND_RANGE;
                r_o_blk   <= '0;
                r_o_slot  <= '0;
                r_o_addr  <= '0;
                r_o_flush <= '0;
                r_o_last  <= 1'b1;
            end
            S_UPD: begin
                r_o_kind  <= blk_full ? KIND_FULL : KIND_STORED;
                r_o_blk   <= r_blk;
                r_o_slot  <= 16'(fill_now);
                r_o_addr  <= 22'(r_blk * cap_eff) + 22'(16'(fill_now));
                r_o_flush <= blk_full ? 16'(fill_next) : 16'd0;
                r_o_last  <= 1'b1;
            end
            S_SDAT: begin
                // emit the previous filled block, hold this one as pending
                r_o_kind    <= KIND_FLUSH;
                r_o_blk     <= r_pend_blk;
                r_o_slot    <= '0;
                r_o_addr    <= r_pend_addr;
                r_o_flush   <= r_pend_fill;
                r_o_last    <= 1'b0;
                r_pend_blk  <= 6'(r_idx);
                r_pend_fill <= 16'(r_rdata);
                r_pend_addr <= 22'(6'(r_idx) * cap_eff);
            end
            S_SEND: begin
                r_o_kind  <= r_pend_vld ? KIND_FLUSH : KIND_NONE;
                r_o_blk   <= r_pend_vld ? r_pend_blk : 6'd0;
                r_o_slot  <= '0;
                r_o_addr  <= r_pend_vld ? r_pend_addr : 22'd0;
                r_o_flush <= r_pend_vld ? r_pend_fill : 16'd0;
                r_o_last  <= 1'b1;
            end
            default: ;
        endcase
    end

    assign o_kind               = r_o_kind;
    assign o_block_id           = r_o_blk;
    assign o_slot               = r_o_slot;
    assign o_buffer_address     = r_o_addr;
    assign o_flush_count        = r_o_flush;
    assign o_last               = r_o_last;
    assign o_edges_written      = r_stored_total;
    assign o_self_loops_dropped = r_loop_total;

`include "edge_block_scatter_top_assert.svh"

    `EBS_ASSERT_NOW(a_flush_nonzero, o_out_valid && o_kind == KIND_FLUSH, o_flush_count != 16'd0, "end flush of an empty block")
    `EBS_ASSERT_NEXT(a_last_to_idle, out_acc && o_last, r_state == S_IDLE, "engine busy after final result")
    `EBS_ASSERT_NEXT(a_total_monotonic, 1'b1, r_stored_total >= $past(r_stored_total), "stored total decreased")
    `EBS_ASSERT_NOW(a_single_result, o_out_valid && o_kind != KIND_FLUSH, o_last, "edge result not marked last")

endmodule
`default_nettype wire
